/* sv/oipa_pkg.sv */
// ----------------------------------------------------------------------------
// oipa_pkg
// Types and codes shared by the ordered identifier pool allocator.
// ----------------------------------------------------------------------------
package oipa_pkg;

    localparam int ID_W = 8;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_ALLOC  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_FREE   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] ident;
        logic            mark_assigned;
    } oipa_in_t;

    typedef struct packed {
        logic [ID_W-1:0] granted_ident;
        logic [1:0]      status;
    } oipa_out_t;

    // one stored list entry
    typedef struct packed {
        logic [ID_W-1:0] ident;
        logic            taken;
    } oipa_entry_t;

    typedef struct packed {
        logic start;
        logic res_free;
    } oipa_ctl_t;

    typedef struct packed {
        logic      idle;
        logic      done;
        oipa_out_t word;
    } oipa_stat_t;

endpackage

/* sv/ordered_id_pool_allocator_unit.sv */
// ----------------------------------------------------------------------------
// ordered_id_pool_allocator_unit
// Ordered pool of 8-bit identifiers with load, update and allocate requests.
// ----------------------------------------------------------------------------
// Request words enter on s_valid/s_ready/s_data, one result word per request
// leaves on m_valid/m_ready/m_data through an output register.
// A load writes its entry (unless the list is full) and then finishes. An
// update or allocate walks the stored list through the RAM read port one
// entry per cycle; an update that hits then appends the updated entry after
// the compacted list, and an allocate stops at the first free entry.
// One request is in flight at a time; s_ready is high only while the
// sequencer is idle, which it is again once its result moves into the
// output register, even if that word is still waiting for m_ready.
// If the receiver stalls with a word held, a finished result waits in the
// sequencer until the output register frees up.
// Reset clears the entry count (empty list) and the handshake state; the
// entry RAM is not cleared, since entries past the count are never read.
// ----------------------------------------------------------------------------
module ordered_id_pool_allocator_unit
    import oipa_pkg::*;
#(
    parameter int POOL_DEPTH = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  oipa_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output oipa_out_t m_data
);

    oipa_ctl_t  ctl;
    oipa_stat_t stat;
    logic       m_valid_reg, m_valid_next;
    oipa_out_t  m_data_reg, m_data_next;

    assign ctl.start    = s_valid && s_ready;
    assign ctl.res_free = !m_valid_reg || m_ready;
    assign s_ready      = stat.idle;

    oipa_walker #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .req     (s_data),
        .stat    (stat)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (ctl.res_free) begin
            m_valid_next = stat.done;
            if (stat.done) begin
                m_data_next = stat.word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a second word while busy");

    a_result_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done && ctl.res_free |=> m_valid && stat.idle)
        else $error("finished result not moved to output register");

    a_grant_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> m_data.granted_ident == '0)
        else $error("nonzero identifier with error status");

endmodule

/* sv/oipa_ram.sv */
// ----------------------------------------------------------------------------
// oipa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oipa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/oipa_walker.sv */
// ----------------------------------------------------------------------------
// oipa_walker
// Sequencer that walks the entry list one entry per cycle through the RAM
// read port, compares each entry and compacts or marks it via the write port.
// ----------------------------------------------------------------------------
module oipa_walker
    import oipa_pkg::*;
#(
    parameter int POOL_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  oipa_ctl_t  ctl,
    input  oipa_in_t   req,
    output oipa_stat_t stat
);

    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int ENT_W = $bits(oipa_entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_WALK,
        S_TAIL,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    oipa_in_t           req_reg, req_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic [CNT_W-1:0]   wptr_reg, wptr_next;
    logic [IDX_W-1:0]   didx_reg, didx_next;
    logic               pend_reg, pend_next;
    logic               found_reg, found_next;
    oipa_out_t          res_reg, res_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    oipa_entry_t        wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENT_W-1:0]   rd_raw;
    oipa_entry_t        rd_data;
    logic               hit;

    assign rd_data = oipa_entry_t'(rd_raw);
    assign rd_addr = issue_reg[IDX_W-1:0];

    oipa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (POOL_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_raw)
    );

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        count_next = count_reg;
        issue_next = issue_reg;
        wptr_next  = wptr_reg;
        didx_next  = didx_reg;
        pend_next  = pend_reg;
        found_next = found_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        hit        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (ctl.start) begin
                    req_next   = req;
                    issue_next = '0;
                    wptr_next  = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    res_next   = '{granted_ident: '0, status: ST_OK};
                    unique case (req.req_type)
                        REQ_LOAD:   state_next = S_LOAD;
                        REQ_UPDATE: state_next = S_WALK;
                        REQ_ALLOC:  state_next = S_WALK;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                if (count_reg == CNT_W'(POOL_DEPTH)) begin
                    res_next.status = ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IDX_W-1:0];
                    wr_data    = '{ident: req_reg.ident, taken: 1'b0};
                    count_next = count_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_WALK: begin
                pend_next = 1'b0;
                // process the entry read last cycle
                if (pend_reg) begin
                    if (req_reg.req_type == REQ_UPDATE) begin
                        if (rd_data.ident == req_reg.ident) begin
                            found_next = 1'b1;
                        end else begin
                            wr_en     = 1'b1;
                            wr_addr   = wptr_reg[IDX_W-1:0];
                            wr_data   = rd_data;
                            wptr_next = wptr_reg + 1'b1;
                        end
                    end else if (!rd_data.taken) begin
                        hit                    = 1'b1;
                        wr_en                  = 1'b1;
                        wr_addr                = didx_reg;
                        wr_data                = '{ident: rd_data.ident, taken: 1'b1};
                        res_next.granted_ident = rd_data.ident;
                        state_next             = S_DONE;
                    end
                end
                if (!hit) begin
                    if (issue_reg < count_reg) begin
                        pend_next  = 1'b1;
                        didx_next  = issue_reg[IDX_W-1:0];
                        issue_next = issue_reg + 1'b1;
                    end else if (!pend_reg) begin
                        if (req_reg.req_type == REQ_UPDATE) begin
                            if (found_reg) begin
                                state_next = S_TAIL;
                            end else begin
                                res_next.status = ST_NOT_FOUND;
                                state_next      = S_DONE;
                            end
                        end else begin
                            res_next.status = ST_NO_FREE;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_TAIL: begin
                // append the updated word after the compacted list
                wr_en      = 1'b1;
                wr_addr    = wptr_reg[IDX_W-1:0];
                wr_data    = '{ident: req_reg.ident, taken: req_reg.mark_assigned};
                count_next = wptr_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (ctl.res_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
        req_reg   <= req_next;
        issue_reg <= issue_next;
        wptr_reg  <= wptr_next;
        didx_reg  <= didx_next;
        res_reg   <= res_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign stat.word = res_reg;

endmodule
